[rtl/core/aea_pkg.sv]
// ----------------------------------------------------------------------------
// aea_pkg
// types and constants shared by the alignment error accounting block
// ----------------------------------------------------------------------------
package aea_pkg;

    localparam logic [1:0] MODE_MD    = 2'd0;
    localparam logic [1:0] MODE_CIGAR = 2'd1;
    localparam logic [1:0] MODE_WALK  = 2'd2;
    localparam logic [1:0] MODE_BIN   = 2'd3;

    localparam logic [1:0] KIND_MATCH = 2'd0;
    localparam logic [1:0] KIND_DEL   = 2'd1;
    localparam logic [1:0] KIND_SUB   = 2'd2;

    localparam logic [1:0] PHASE_NONE  = 2'd0;
    localparam logic [1:0] PHASE_MATCH = 2'd1;
    localparam logic [1:0] PHASE_DEL   = 2'd2;
    localparam logic [1:0] PHASE_SUB   = 2'd3;

    localparam logic [3:0] CIG_M  = 4'd0;
    localparam logic [3:0] CIG_I  = 4'd1;
    localparam logic [3:0] CIG_D  = 4'd2;
    localparam logic [3:0] CIG_EQ = 4'd7;
    localparam logic [3:0] CIG_X  = 4'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_STOPPED  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5a;

    localparam logic [9:0] BINS_RESET = 10'd400;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  md_char;
        logic [3:0]  cigar_kind;
        logic [15:0] cigar_count;
        logic        reverse_strand;
        logic [8:0]  bin_index;
        logic        clear_after_read;
    } item_in_t;

    typedef struct packed {
        logic [15:0] aligned_bases;
        logic [15:0] error_count;
        logic [15:0] q10_bases;
        logic [15:0] q17_bases;
        logic [31:0] bin_value;
        logic [1:0]  status;
    } item_out_t;

endpackage

[rtl/core/aea_hist.sv]
// ----------------------------------------------------------------------------
// aea_hist
// error position histogram: one memory, add or clear by read-modify-write
// ----------------------------------------------------------------------------
module aea_hist #(
    parameter int HIST_BINS = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(HIST_BINS)-1:0] rd_addr,
    output logic [31:0]                  rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(HIST_BINS)-1:0] wr_addr,
    input  logic [31:0]                  wr_data,
    output logic                         clearing
);
    localparam int AW = $clog2(HIST_BINS);

    logic [31:0]   mem [HIST_BINS];
    logic [AW:0]   clr_reg;

    assign clearing = !clr_reg[AW];

    // clearing pass after reset, one bin a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_reg[AW-1:0]] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/aea_lists.sv]
// ----------------------------------------------------------------------------
// aea_lists
// md run list and cigar op list memories
// ----------------------------------------------------------------------------
module aea_lists #(
    parameter int MAX_MD_OPS      = 256,
    parameter int MAX_CIGAR_OPS   = 64,
    parameter int RUN_LENGTH_BITS = 16
) (
    input  logic                             clk,
    input  logic                             md_rd_en,
    input  logic [$clog2(MAX_MD_OPS)-1:0]    md_rd_addr,
    output logic [1:0]                       md_rd_kind,
    output logic [RUN_LENGTH_BITS-1:0]       md_rd_len,
    input  logic                             md_wr_en,
    input  logic [$clog2(MAX_MD_OPS)-1:0]    md_wr_addr,
    input  logic [1:0]                       md_wr_kind,
    input  logic [RUN_LENGTH_BITS-1:0]       md_wr_len,
    input  logic                             cg_rd_en,
    input  logic [$clog2(MAX_CIGAR_OPS)-1:0] cg_rd_addr,
    output logic [3:0]                       cg_rd_kind,
    output logic [RUN_LENGTH_BITS-1:0]       cg_rd_len,
    input  logic                             cg_wr_en,
    input  logic [$clog2(MAX_CIGAR_OPS)-1:0] cg_wr_addr,
    input  logic [3:0]                       cg_wr_kind,
    input  logic [RUN_LENGTH_BITS-1:0]       cg_wr_len
);
    logic [RUN_LENGTH_BITS+1:0] md_mem [MAX_MD_OPS];
    logic [RUN_LENGTH_BITS+3:0] cg_mem [MAX_CIGAR_OPS];

    always_ff @(posedge clk)
    begin
        if (md_wr_en)
        begin
            md_mem[md_wr_addr] <= {md_wr_kind, md_wr_len};
        end
        if (md_rd_en)
        begin
            {md_rd_kind, md_rd_len} <= md_mem[md_rd_addr];
        end
        if (cg_wr_en)
        begin
            cg_mem[cg_wr_addr] <= {cg_wr_kind, cg_wr_len};
        end
        if (cg_rd_en)
        begin
            {cg_rd_kind, cg_rd_len} <= cg_mem[cg_rd_addr];
        end
    end

endmodule

[rtl/core/alignment_error_accounting.sv]
// ----------------------------------------------------------------------------
// alignment_error_accounting
// per read error accounting from md tag and cigar, with error histogram
// ----------------------------------------------------------------------------
// a command is taken when start is high and busy low; its result appears on
// result for one cycle with done high, and the receiver cannot stall it.
// busy drops in the result cycle, so the next command can be taken there.
// mode 0 loads one md character (the last run is re-read and, when the
// character extends it, written back). mode 1 appends a cigar op. mode 3
// reads a bin and optionally clears it.
// mode 2 walks both lists. each new list entry costs a fetch, a load step
// for the registered memory read and a skip step; each counting step is a
// step, then the aq update, and every histogram bin touched adds a
// read-modify-write.
// after reset a clearing pass zeroes the histogram, and busy stays high
// during it; configuration writes are taken at all times.
// ----------------------------------------------------------------------------
module alignment_error_accounting #(
    parameter int MAX_MD_OPS      = 256,
    parameter int MAX_CIGAR_OPS   = 64,
    parameter int HIST_BINS       = 512,
    parameter int RUN_LENGTH_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  aea_pkg::item_in_t  item,
    output logic               done,
    output aea_pkg::item_out_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import aea_pkg::*;

    localparam int MW = $clog2(MAX_MD_OPS);
    localparam int CW = $clog2(MAX_CIGAR_OPS);
    localparam int HW = $clog2(HIST_BINS);
    localparam int RL = RUN_LENGTH_BITS;
    localparam logic [RL-1:0] RUN_MAX = {RL{1'b1}};

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MDRD   = 4'd1;
    localparam logic [3:0] S_MDWR   = 4'd2;
    localparam logic [3:0] S_BINRD  = 4'd3;
    localparam logic [3:0] S_BINWR  = 4'd4;
    localparam logic [3:0] S_FETCH  = 4'd5;
    localparam logic [3:0] S_STEP   = 4'd6;
    localparam logic [3:0] S_HRD    = 4'd7;
    localparam logic [3:0] S_HWR    = 4'd8;
    localparam logic [3:0] S_AQ     = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;
    localparam logic [3:0] S_LOAD   = 4'd11;

    logic [3:0]       state_reg;
    item_in_t         cmd_reg;
    logic [9:0]       bins_reg;
    logic [MW:0]      md_fill_reg;
    logic [CW:0]      cg_fill_reg;
    logic [1:0]       phase_reg;
    logic             ovf_reg;
    logic             done_reg;
    item_out_t        res_reg;

    // walk registers
    logic [MW:0]      mi_reg;
    logic [CW:0]      ci_reg;
    logic             md_need_reg;
    logic             cg_need_reg;
    logic [1:0]       mk_reg;
    logic [RL-1:0]    ml_reg;
    logic [3:0]       ck_reg;
    logic [RL-1:0]    cl_reg;
    logic [31:0]      bases_reg;
    logic [31:0]      errors_reg;
    logic [31:0]      aq10_reg;
    logic [31:0]      aq17_reg;
    logic             stopped_reg;
    logic [RL-1:0]    hcnt_reg;
    logic [31:0]      hpos_reg;
    logic [31:0]      hamt_reg;
    logic             hsingle_reg;

    // memory ports
    logic             md_rd_en;
    logic [MW-1:0]    md_rd_addr;
    logic [1:0]       md_rd_kind;
    logic [RL-1:0]    md_rd_len;
    logic             md_wr_en;
    logic [MW-1:0]    md_wr_addr;
    logic [1:0]       md_wr_kind;
    logic [RL-1:0]    md_wr_len;
    logic             cg_rd_en;
    logic [CW-1:0]    cg_rd_addr;
    logic [3:0]       cg_rd_kind;
    logic [RL-1:0]    cg_rd_len;
    logic             cg_wr_en;
    logic [CW-1:0]    cg_wr_addr;
    logic             h_rd_en;
    logic [HW-1:0]    h_rd_addr;
    logic [31:0]      h_rd_data;
    logic             h_wr_en;
    logic [HW-1:0]    h_wr_addr;
    logic [31:0]      h_wr_data;
    logic             clearing;
    logic [RL-1:0]    cnt_sat;

    generate
        if (RL < 16)
        begin : g_sat
            assign cnt_sat = (|cmd_reg.cigar_count[15:RL]) ? RUN_MAX : '0;
        end
        else
        begin : g_nosat
            assign cnt_sat = '0;
        end
    endgenerate

    aea_lists #(
        .MAX_MD_OPS      (MAX_MD_OPS),
        .MAX_CIGAR_OPS   (MAX_CIGAR_OPS),
        .RUN_LENGTH_BITS (RUN_LENGTH_BITS)
    ) u_lists (
        .clk        (clk),
        .md_rd_en   (md_rd_en),
        .md_rd_addr (md_rd_addr),
        .md_rd_kind (md_rd_kind),
        .md_rd_len  (md_rd_len),
        .md_wr_en   (md_wr_en),
        .md_wr_addr (md_wr_addr),
        .md_wr_kind (md_wr_kind),
        .md_wr_len  (md_wr_len),
        .cg_rd_en   (cg_rd_en),
        .cg_rd_addr (cg_rd_addr),
        .cg_rd_kind (cg_rd_kind),
        .cg_rd_len  (cg_rd_len),
        .cg_wr_en   (cg_wr_en),
        .cg_wr_addr (cg_wr_addr),
        .cg_wr_kind (cmd_reg.cigar_kind),
        .cg_wr_len  (RL'(cmd_reg.cigar_count) | cnt_sat)
    );

    aea_hist #(
        .HIST_BINS (HIST_BINS)
    ) u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (h_rd_en),
        .rd_addr  (h_rd_addr),
        .rd_data  (h_rd_data),
        .wr_en    (h_wr_en),
        .wr_addr  (h_wr_addr),
        .wr_data  (h_wr_data),
        .clearing (clearing)
    );

    // configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {22'd0, bins_reg} : 32'd0;

    assign busy   = (state_reg != S_IDLE) || clearing;
    assign done   = done_reg;
    assign result = res_reg;

    // bins limit clamped to memory depth
    logic [31:0] lim;
    assign lim = ({22'd0, bins_reg} > 32'(HIST_BINS)) ? 32'(HIST_BINS)
                                                     : {22'd0, bins_reg};

    // md char classes
    logic is_dig, is_caret, is_let;
    logic [3:0] dig;
    assign is_dig   = (cmd_reg.md_char >= CH_0) && (cmd_reg.md_char <= CH_9);
    assign is_caret = (cmd_reg.md_char == CH_CARET);
    assign is_let   = (cmd_reg.md_char >= CH_A) && (cmd_reg.md_char <= CH_Z);
    assign dig      = 4'(cmd_reg.md_char - CH_0);

    logic md_extend;
    assign md_extend = (md_fill_reg != '0) &&
                       ((is_dig && phase_reg == PHASE_MATCH) ||
                        (is_let && (phase_reg == PHASE_DEL || phase_reg == PHASE_SUB)));

    logic [RL+3:0] len10;
    assign len10 = ({4'd0, md_rd_len} << 3) + ({4'd0, md_rd_len} << 1) + {{RL{1'b0}}, dig};

    // walk step decode
    logic          ck_match, md_end, cg_end;
    logic [RL-1:0] adv;
    assign ck_match = (ck_reg == CIG_M) || (ck_reg == CIG_EQ) || (ck_reg == CIG_X);
    assign adv      = (cl_reg < ml_reg) ? cl_reg : ml_reg;
    assign cg_end   = cmd_reg.reverse_strand ? (ci_reg == '0) : (ci_reg == cg_fill_reg);
    assign md_end   = cmd_reg.reverse_strand ? (mi_reg == '0) : (mi_reg == md_fill_reg);

    logic [MW-1:0] mi_addr;
    logic [CW-1:0] ci_addr;
    assign mi_addr = cmd_reg.reverse_strand ? MW'(mi_reg - 1'b1) : mi_reg[MW-1:0];
    assign ci_addr = cmd_reg.reverse_strand ? CW'(ci_reg - 1'b1) : ci_reg[CW-1:0];

    logic [32:0] hsum;
    assign hsum = {1'b0, h_rd_data} + {1'b0, hamt_reg};

    function automatic logic [15:0] sat16(input logic [31:0] v);
        sat16 = (|v[31:16]) ? 16'hffff : v[15:0];
    endfunction

    always_comb
    begin
        md_rd_en   = 1'b0;
        md_rd_addr = MW'(md_fill_reg - 1'b1);
        md_wr_en   = 1'b0;
        md_wr_addr = md_fill_reg[MW-1:0];
        md_wr_kind = KIND_MATCH;
        md_wr_len  = '0;
        cg_rd_en   = 1'b0;
        cg_rd_addr = ci_addr;
        cg_wr_en   = 1'b0;
        cg_wr_addr = cg_fill_reg[CW-1:0];
        h_rd_en    = 1'b0;
        h_rd_addr  = HW'(cmd_reg.bin_index);
        h_wr_en    = 1'b0;
        h_wr_addr  = hpos_reg[HW-1:0];
        h_wr_data  = hsum[32] ? 32'hffffffff : hsum[31:0];
        case (state_reg)
            S_IDLE:
            begin
                md_rd_en = 1'b1;
            end
            S_MDWR:
            begin
                if (md_extend)
                begin
                    md_wr_en   = 1'b1;
                    md_wr_addr = MW'(md_fill_reg - 1'b1);
                    md_wr_kind = md_rd_kind;
                    if (is_dig)
                    begin
                        md_wr_len = (|len10[RL+3:RL]) ? RUN_MAX : len10[RL-1:0];
                    end
                    else
                    begin
                        md_wr_len = (md_rd_len == RUN_MAX) ? RUN_MAX : md_rd_len + 1'b1;
                    end
                end
                else if ((is_dig || is_caret || is_let) && !md_fill_reg[MW])
                begin
                    md_wr_en   = 1'b1;
                    md_wr_kind = is_dig ? KIND_MATCH : (is_caret ? KIND_DEL : KIND_SUB);
                    md_wr_len  = is_dig ? RL'(dig) : (is_caret ? '0 : RL'(1));
                end
            end
            S_BINRD:
            begin
                cg_wr_en = (cmd_reg.mode == MODE_CIGAR) && !cg_fill_reg[CW];
                h_rd_en  = (cmd_reg.mode == MODE_BIN);
            end
            S_BINWR:
            begin
                h_wr_en   = (cmd_reg.mode == MODE_BIN) && cmd_reg.clear_after_read &&
                            (32'(cmd_reg.bin_index) < 32'(HIST_BINS));
                h_wr_addr = HW'(cmd_reg.bin_index);
                h_wr_data = '0;
            end
            S_FETCH:
            begin
                md_rd_en   = 1'b1;
                md_rd_addr = mi_addr;
                cg_rd_en   = 1'b1;
            end
            S_HRD:
            begin
                h_rd_en   = 1'b1;
                h_rd_addr = hpos_reg[HW-1:0];
            end
            S_HWR:
            begin
                h_wr_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bins_reg    <= BINS_RESET;
            md_fill_reg <= '0;
            cg_fill_reg <= '0;
            phase_reg   <= PHASE_NONE;
            ovf_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr)
            begin
                bins_reg <= pwdata[9:0];
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start && !clearing)
                    begin
                        case (item.mode)
                            MODE_MD:    state_reg <= S_MDRD;
                            MODE_WALK:  state_reg <= S_FETCH;
                            default:    state_reg <= S_BINRD;
                        endcase
                    end
                end
                S_MDRD:
                begin
                    state_reg <= S_MDWR;
                end
                S_MDWR:
                begin
                    if (!md_extend && (is_dig || is_caret || is_let))
                    begin
                        if (md_fill_reg[MW])
                        begin
                            ovf_reg   <= 1'b1;
                            phase_reg <= PHASE_NONE;
                        end
                        else
                        begin
                            md_fill_reg <= md_fill_reg + 1'b1;
                            phase_reg   <= is_dig ? PHASE_MATCH :
                                           (is_caret ? PHASE_DEL : PHASE_SUB);
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_BINRD:
                begin
                    if (cmd_reg.mode == MODE_CIGAR)
                    begin
                        if (cg_fill_reg[CW])
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            cg_fill_reg <= cg_fill_reg + 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_BINWR;
                    end
                end
                S_BINWR:
                begin
                    state_reg <= S_DONE;
                end
                S_FETCH:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    state_reg <= S_STEP;
                    if (md_need_reg || cg_need_reg)
                    begin
                        state_reg <= S_FETCH;
                    end
                    else if (stopped_reg || cg_end || md_end)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (cl_reg == '0 || ml_reg == '0)
                    begin
                        state_reg <= S_FETCH;
                    end
                    else if ((ck_match && mk_reg == KIND_MATCH) ||
                             (ck_reg == CIG_D && mk_reg == KIND_DEL))
                    begin
                        state_reg <= (ck_reg == CIG_D && mk_reg == KIND_DEL &&
                                      bases_reg < lim) ? S_HRD : S_AQ;
                    end
                    else if (ck_reg == CIG_I || mk_reg == KIND_SUB)
                    begin
                        state_reg <= (bases_reg < lim) ? S_HRD : S_AQ;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_HRD:
                begin
                    state_reg <= S_HWR;
                end
                S_HWR:
                begin
                    // position and count move at this same edge
                    state_reg <= (!hsingle_reg && hcnt_reg != RL'(1) &&
                                  (hpos_reg + 32'd1) < lim) ? S_HRD : S_AQ;
                end
                S_AQ:
                begin
                    state_reg <= S_STEP;
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    if (cmd_reg.mode == MODE_WALK)
                    begin
                        md_fill_reg <= '0;
                        cg_fill_reg <= '0;
                        phase_reg   <= PHASE_NONE;
                        ovf_reg     <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg     <= item;
                mi_reg      <= item.reverse_strand ? md_fill_reg : '0;
                ci_reg      <= item.reverse_strand ? cg_fill_reg : '0;
                bases_reg   <= '0;
                errors_reg  <= '0;
                aq10_reg    <= '0;
                aq17_reg    <= '0;
                stopped_reg <= 1'b0;
                md_need_reg <= 1'b1;
                cg_need_reg <= 1'b1;
            end
            S_LOAD:
            begin
                // entry data is on the memory outputs in the cycle after the fetch
                if (cg_need_reg && !cg_end)
                begin
                    ck_reg <= cg_rd_kind;
                    cl_reg <= cg_rd_len;
                end
                if (md_need_reg && !md_end)
                begin
                    mk_reg <= md_rd_kind;
                    ml_reg <= md_rd_len;
                end
                md_need_reg <= 1'b0;
                cg_need_reg <= 1'b0;
            end
            S_STEP:
            begin
                if (md_need_reg || cg_need_reg)
                begin
                end
                else if (cg_end || md_end || stopped_reg)
                begin
                end
                else if (cl_reg == '0)
                begin
                    ci_reg      <= cmd_reg.reverse_strand ? ci_reg - 1'b1 : ci_reg + 1'b1;
                end
                else if (ml_reg == '0)
                begin
                    mi_reg      <= cmd_reg.reverse_strand ? mi_reg - 1'b1 : mi_reg + 1'b1;
                end
                else if (ck_match && mk_reg == KIND_MATCH)
                begin
                    bases_reg <= bases_reg + 32'(adv);
                    cl_reg    <= cl_reg - adv;
                    ml_reg    <= ml_reg - adv;
                end
                else if (ck_reg == CIG_I)
                begin
                    hpos_reg    <= bases_reg;
                    hcnt_reg    <= cl_reg;
                    hamt_reg    <= 32'd1;
                    hsingle_reg <= 1'b0;
                    bases_reg   <= bases_reg + 32'(cl_reg);
                    errors_reg  <= errors_reg + 32'(cl_reg);
                    cl_reg      <= '0;
                end
                else if (ck_reg == CIG_D && mk_reg == KIND_DEL)
                begin
                    hpos_reg    <= bases_reg;
                    hcnt_reg    <= adv;
                    hamt_reg    <= 32'(adv);
                    hsingle_reg <= 1'b1;
                    errors_reg  <= errors_reg + 32'(adv);
                    cl_reg      <= cl_reg - adv;
                    ml_reg      <= ml_reg - adv;
                end
                else if (mk_reg == KIND_SUB)
                begin
                    hpos_reg    <= bases_reg;
                    hcnt_reg    <= adv;
                    hamt_reg    <= 32'd1;
                    hsingle_reg <= 1'b0;
                    bases_reg   <= bases_reg + 32'(adv);
                    errors_reg  <= errors_reg + 32'(adv);
                    cl_reg      <= cl_reg - adv;
                    ml_reg      <= ml_reg - adv;
                end
                else
                begin
                    stopped_reg <= 1'b1;
                end
                // an index move asks for a new entry from memory
                if (!(md_need_reg || cg_need_reg) && !(cg_end || md_end || stopped_reg))
                begin
                    if (cl_reg == '0)
                    begin
                        cg_need_reg <= 1'b1;
                    end
                    else if (ml_reg == '0)
                    begin
                        md_need_reg <= 1'b1;
                    end
                end
            end
            S_HWR:
            begin
                hpos_reg <= hpos_reg + 1'b1;
                hcnt_reg <= hcnt_reg - 1'b1;
            end
            S_AQ:
            begin
                if ({errors_reg, 3'd0} + {2'd0, errors_reg, 1'd0} <= {3'd0, bases_reg})
                begin
                    aq10_reg <= bases_reg;
                end
                if (({errors_reg, 5'd0} + {1'd0, errors_reg, 4'd0}
                     + {4'd0, errors_reg, 1'd0}) <= {5'd0, bases_reg})
                begin
                    aq17_reg <= bases_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE)
        begin
            res_reg <= '0;
            case (cmd_reg.mode)
                MODE_WALK:
                begin
                    res_reg.aligned_bases <= sat16(bases_reg);
                    res_reg.error_count   <= sat16(errors_reg);
                    res_reg.q10_bases     <= sat16(aq10_reg);
                    res_reg.q17_bases     <= sat16(aq17_reg);
                    res_reg.status        <= ovf_reg ? ST_OVERFLOW :
                                             (stopped_reg ? ST_STOPPED : ST_OK);
                end
                MODE_BIN:
                begin
                    res_reg.bin_value <= (32'(cmd_reg.bin_index) < 32'(HIST_BINS))
                                         ? h_rd_data : 32'd0;
                end
                default:
                begin
                    res_reg.status <= ovf_reg ? ST_OVERFLOW : ST_OK;
                end
            endcase
        end
    end

endmodule

[rtl/core/aea_checker.sv]
// ----------------------------------------------------------------------------
// aea_checker
// port level checks on the command and result channels
// ----------------------------------------------------------------------------
module aea_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input aea_pkg::item_out_t result
);
    import aea_pkg::*;

    // a transfer always makes the block busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // results only come out of a busy block
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without command");

    // one result per command
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");

    // status never takes the unused code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status != 2'd3))
        else $error("bad status code");

endmodule

bind alignment_error_accounting aea_checker u_aea_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
